FILE: sv/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk_s, rstn_s, expr, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (expr)) else $error(msg);

// Consequent must hold in the same cycle whenever the antecedent holds.
`define ASSERT_IMPLY(lbl, clk_s, rstn_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: sv/vnb2d_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vnb2d_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int COORD_W    = 32;
    localparam int FREQ_W     = 16;
    localparam int AMP_W      = 16;
    localparam int WRAP_W     = 32;
    localparam int SEED_W     = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int NOISE_W    = 26;

    // coordinate Q16.16 times frequency Q8.8
    localparam int PROD_W    = COORD_W + FREQ_W;
    localparam int PROD_FRAC = 24;
    localparam int IDX_W     = PROD_W - PROD_FRAC;

    // remainder pipeline: bits retired per stage
    localparam int DIV_BITS = 2;
    localparam int DIV_ST   = IDX_W / DIV_BITS;

    // corner sample, signed, range [-2^FRAC_BITS + 1, 2^FRAC_BITS]
    localparam int SMP_W = FRAC_BITS + 2;
    localparam int LP_W  = SMP_W + FRAC_BITS + 2;
    localparam int SC_W  = SMP_W + AMP_W + 1;

    localparam logic [31:0] HASH_MUL_B = 32'd1103515245;
    localparam logic [31:0] HASH_ADD_B = 32'd12345;
    localparam logic [31:0] HASH_MUL_R = 32'd16807;
    localparam logic [31:0] HASH_ADD_R = 32'd2147483647;

    localparam logic [CFG_IDX_W-1:0] REG_FREQUENCY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WRAP_PERIOD = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SEED        = 2'd3;

    localparam logic [FREQ_W-1:0] FREQ_RESET = 16'd256;
    localparam logic [AMP_W-1:0]  AMP_RESET  = 16'd256;

    // One restoring step of r = n mod p. A zero modulus passes n through.
    function automatic logic [IDX_W-1:0] rem_step(input logic [IDX_W-1:0] r,
                                                  input logic nb,
                                                  input logic [WRAP_W-1:0] p);
        logic [IDX_W:0] t;
        begin
            t = {r, nb};
            if (WRAP_W'(t) >= p)
            begin
                t = t - p[IDX_W:0];
            end
            return t[IDX_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

FILE: sv/value_noise_bilinear_2d.sv
// 2D value noise with bilinear blend. When the output side does not stall, one
// coordinate word enters per clock and the throughput is one word per cycle.
// The pipeline length is set by the lattice-index remainder (index mod
// wrap_period), worked two bits per stage over 12 stages, plus the hash (two
// multiplier stages) and the three blend multiplies. A stall only holds the
// stages that are full, so bubbles collapse. Configuration must be written
// only while the pipeline is empty.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module value_noise_bilinear_2d
(
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   cfg_we,
    input  wire logic [vnb2d_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [vnb2d_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  wire logic                                   in_valid,
    output logic                                        in_stall,
    input  wire logic [vnb2d_pkg::COORD_W-1:0]          coord_x,
    input  wire logic [vnb2d_pkg::COORD_W-1:0]          coord_y,
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output logic signed [vnb2d_pkg::NOISE_W-1:0]        noise_value
);
    import vnb2d_pkg::*;

    localparam int ST_MUL  = 0;
    localparam int ST_DIV0 = 1;
    localparam int ST_CRN  = ST_DIV0 + DIV_ST;
    localparam int ST_H1   = ST_CRN + 1;
    localparam int ST_H2   = ST_H1 + 1;
    localparam int ST_H3   = ST_H2 + 1;
    localparam int ST_SMP  = ST_H3 + 1;
    localparam int ST_L1   = ST_SMP + 1;
    localparam int ST_L2   = ST_L1 + 1;
    localparam int ST_L3   = ST_L2 + 1;
    localparam int ST_L4   = ST_L3 + 1;
    localparam int ST_L5   = ST_L4 + 1;
    localparam int ST_OUT  = ST_L5 + 1;
    localparam int NST     = ST_OUT + 1;

    // configuration
    logic [FREQ_W-1:0] freq_reg;
    logic [AMP_W-1:0]  amp_reg;
    logic [WRAP_W-1:0] wrap_reg;
    logic [SEED_W-1:0] seed_reg;

    // flow control
    logic [NST-1:0] vld_reg;
    logic [NST-1:0] vld_next;
    logic [NST-1:0] adv;

    // stage registers
    logic [PROD_W-1:0]    px_reg, py_reg;
    logic [IDX_W-1:0]     xrem_reg [DIV_ST];
    logic [IDX_W-1:0]     xnum_reg [DIV_ST];
    logic [IDX_W-1:0]     yrem_reg [DIV_ST];
    logic [IDX_W-1:0]     ynum_reg [DIV_ST];
    logic [FRAC_BITS-1:0] txd_reg  [DIV_ST];
    logic [FRAC_BITS-1:0] tyd_reg  [DIV_ST];
    logic [IDX_W-1:0]     xrem_next [DIV_ST];
    logic [IDX_W-1:0]     xnum_next [DIV_ST];
    logic [IDX_W-1:0]     yrem_next [DIV_ST];
    logic [IDX_W-1:0]     ynum_next [DIV_ST];
    logic [FRAC_BITS-1:0] txd_next  [DIV_ST];
    logic [FRAC_BITS-1:0] tyd_next  [DIV_ST];

    logic [31:0] cx_reg [2];
    logic [31:0] cy_reg [2];
    logic [31:0] cx_next [2];
    logic [31:0] cy_next [2];
    logic [31:0] h1_reg [4];
    logic [31:0] h1_next [4];
    logic [31:0] bm_reg [2];
    logic [31:0] bm_next [2];
    logic [31:0] h2_reg [4];
    logic [31:0] h2_next [4];
    logic [31:0] h3_reg [4];
    logic [31:0] h3_next [4];
    logic signed [SMP_W-1:0] smp_reg [4];
    logic signed [SMP_W-1:0] smp_next [4];

    // fraction weights carried past the remainder stages
    logic [FRAC_BITS-1:0] tx_reg [ST_CRN:ST_SMP];
    logic [FRAC_BITS-1:0] ty_reg [ST_CRN:ST_L2];

    logic signed [SMP_W-1:0] a0_reg, a2_reg;
    logic signed [LP_W-1:0]  ptop_reg, pbot_reg;
    logic signed [LP_W-1:0]  ptop_next, pbot_next;
    logic signed [SMP_W-1:0] top_reg, bot_reg, top3_reg;
    logic signed [SMP_W-1:0] top_next, bot_next;
    logic signed [LP_W-1:0]  pv_reg, pv_next;
    logic signed [SMP_W-1:0] v_reg, v_next;
    logic signed [SC_W-1:0]  sc_reg, sc_next;
    logic signed [NOISE_W-1:0] noise_reg, noise_next;

    logic smp_ok;

    // ---------------------------------------------------------------
    // configuration port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_reg <= FREQ_RESET;
            amp_reg  <= AMP_RESET;
            wrap_reg <= '0;
            seed_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FREQUENCY:   freq_reg <= cfg_wdata[FREQ_W-1:0];
                REG_AMPLITUDE:   amp_reg  <= cfg_wdata[AMP_W-1:0];
                REG_WRAP_PERIOD: wrap_reg <= cfg_wdata[WRAP_W-1:0];
                REG_SEED:        seed_reg <= cfg_wdata[SEED_W-1:0];
                default:         ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // stage advance: a stage loads when it is empty or the next one loads
    always_comb
    begin
        adv[NST-1] = !vld_reg[NST-1] || !out_stall;
        for (int k = NST - 2; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
        vld_next = {vld_reg[NST-2:0], in_valid};
    end

    assign in_stall    = !adv[0];
    assign out_valid   = vld_reg[ST_OUT];
    assign noise_value = noise_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NST; k++)
            begin
                if (adv[k])
                begin
                    vld_reg[k] <= vld_next[k];
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // lattice index remainder, two bits per stage
    always_comb
    begin
        logic [IDX_W-1:0] xr, xn, yr, yn;
        for (int k = 0; k < DIV_ST; k++)
        begin
            if (k == 0)
            begin
                xr = '0;
                yr = '0;
                xn = px_reg[PROD_W-1 -: IDX_W];
                yn = py_reg[PROD_W-1 -: IDX_W];
                txd_next[k] = px_reg[PROD_FRAC-1 -: FRAC_BITS];
                tyd_next[k] = py_reg[PROD_FRAC-1 -: FRAC_BITS];
            end
            else
            begin
                xr = xrem_reg[k-1];
                yr = yrem_reg[k-1];
                xn = xnum_reg[k-1];
                yn = ynum_reg[k-1];
                txd_next[k] = txd_reg[k-1];
                tyd_next[k] = tyd_reg[k-1];
            end
            for (int b = 0; b < DIV_BITS; b++)
            begin
                xr = rem_step(xr, xn[IDX_W-1], wrap_reg);
                yr = rem_step(yr, yn[IDX_W-1], wrap_reg);
                xn = {xn[IDX_W-2:0], 1'b0};
                yn = {yn[IDX_W-2:0], 1'b0};
            end
            xrem_next[k] = xr;
            yrem_next[k] = yr;
            xnum_next[k] = xn;
            ynum_next[k] = yn;
        end
    end

    // ---------------------------------------------------------------
    // corners, hash, blend
    always_comb
    begin
        logic [IDX_W:0]  xr1, yr1;
        logic [31:0]     t;
        logic [31:0]     rr;
        logic signed [SMP_W:0] dt, db, dv;

        // far corner: (r + 1) mod p, the remainder is already below p
        xr1 = {1'b0, xrem_reg[DIV_ST-1]} + 1'b1;
        yr1 = {1'b0, yrem_reg[DIV_ST-1]} + 1'b1;
        cx_next[0] = 32'(xrem_reg[DIV_ST-1]) ^ seed_reg;
        cy_next[0] = 32'(yrem_reg[DIV_ST-1]) ^ seed_reg;
        cx_next[1] = ((wrap_reg != '0) && (32'(xr1) == wrap_reg)) ? seed_reg
                                                                  : (32'(xr1) ^ seed_reg);
        cy_next[1] = ((wrap_reg != '0) && (32'(yr1) == wrap_reg)) ? seed_reg
                                                                  : (32'(yr1) ^ seed_reg);

        // lanes: 0 (x0,y0), 1 (x1,y0), 2 (x0,y1), 3 (x1,y1)
        for (int i = 0; i < 4; i++)
        begin
            h1_next[i] = cx_reg[i & 1] ^ ~(cy_reg[i >> 1] << 7);
        end
        for (int j = 0; j < 2; j++)
        begin
            bm_next[j] = 32'(cy_reg[j] * HASH_MUL_B);
        end

        for (int i = 0; i < 4; i++)
        begin
            t = h1_reg[i];
            t = t - ((t << 23) ^ (bm_reg[i >> 1] + HASH_ADD_B));
            t = t ^ (t << 24);
            t = t - ~(t << 6);
            h2_next[i] = t;
            h3_next[i] = 32'(h2_reg[i] * HASH_MUL_R);
            rr = h3_reg[i] + HASH_ADD_R;
            smp_next[i] = SMP_W'(1 << FRAC_BITS) - SMP_W'(rr >> (31 - FRAC_BITS));
        end

        dt = (SMP_W+1)'(smp_reg[1]) - (SMP_W+1)'(smp_reg[0]);
        db = (SMP_W+1)'(smp_reg[3]) - (SMP_W+1)'(smp_reg[2]);
        ptop_next = dt * $signed({1'b0, tx_reg[ST_SMP]});
        pbot_next = db * $signed({1'b0, tx_reg[ST_SMP]});

        top_next = a0_reg + SMP_W'(ptop_reg >>> FRAC_BITS);
        bot_next = a2_reg + SMP_W'(pbot_reg >>> FRAC_BITS);

        dv = (SMP_W+1)'(bot_reg) - (SMP_W+1)'(top_reg);
        pv_next = dv * $signed({1'b0, ty_reg[ST_L2]});

        v_next = top3_reg + SMP_W'(pv_reg >>> FRAC_BITS);

        sc_next = v_reg * $signed({1'b0, amp_reg});

        noise_next = NOISE_W'(sc_reg >>> (FRAC_BITS - 8));
    end

    // ---------------------------------------------------------------
    // payload registers
    always_ff @(posedge clk)
    begin
        if (adv[ST_MUL])
        begin
            px_reg <= PROD_W'(coord_x * freq_reg);
            py_reg <= PROD_W'(coord_y * freq_reg);
        end
        for (int k = 0; k < DIV_ST; k++)
        begin
            if (adv[ST_DIV0 + k])
            begin
                xrem_reg[k] <= xrem_next[k];
                yrem_reg[k] <= yrem_next[k];
                xnum_reg[k] <= xnum_next[k];
                ynum_reg[k] <= ynum_next[k];
                txd_reg[k]  <= txd_next[k];
                tyd_reg[k]  <= tyd_next[k];
            end
        end
        if (adv[ST_CRN])
        begin
            cx_reg <= cx_next;
            cy_reg <= cy_next;
            tx_reg[ST_CRN] <= txd_reg[DIV_ST-1];
            ty_reg[ST_CRN] <= tyd_reg[DIV_ST-1];
        end
        for (int k = ST_CRN + 1; k <= ST_SMP; k++)
        begin
            if (adv[k])
            begin
                tx_reg[k] <= tx_reg[k-1];
            end
        end
        for (int k = ST_CRN + 1; k <= ST_L2; k++)
        begin
            if (adv[k])
            begin
                ty_reg[k] <= ty_reg[k-1];
            end
        end
        if (adv[ST_H1])
        begin
            h1_reg <= h1_next;
            bm_reg <= bm_next;
        end
        if (adv[ST_H2])
        begin
            h2_reg <= h2_next;
        end
        if (adv[ST_H3])
        begin
            h3_reg <= h3_next;
        end
        if (adv[ST_SMP])
        begin
            smp_reg <= smp_next;
        end
        if (adv[ST_L1])
        begin
            ptop_reg <= ptop_next;
            pbot_reg <= pbot_next;
            a0_reg   <= smp_reg[0];
            a2_reg   <= smp_reg[2];
        end
        if (adv[ST_L2])
        begin
            top_reg <= top_next;
            bot_reg <= bot_next;
        end
        if (adv[ST_L3])
        begin
            pv_reg   <= pv_next;
            top3_reg <= top_reg;
        end
        if (adv[ST_L4])
        begin
            v_reg <= v_next;
        end
        if (adv[ST_L5])
        begin
            sc_reg <= sc_next;
        end
        if (adv[ST_OUT])
        begin
            noise_reg <= noise_next;
        end
    end

    // ---------------------------------------------------------------
    // checks
    always_comb
    begin
        smp_ok = 1'b1;
        for (int i = 0; i < 4; i++)
        begin
            if ((smp_reg[i] > $signed(SMP_W'(1 << FRAC_BITS))) ||
                (smp_reg[i] < -$signed(SMP_W'((1 << FRAC_BITS) - 1))))
            begin
                smp_ok = 1'b0;
            end
        end
    end

    `ASSERT_IMPLY(a_stall_only_full, clk, rst_n, in_stall, (&vld_reg) && out_stall, "input stalled with a free stage")
    `ASSERT_IMPLY(a_rem_below_wrap, clk, rst_n, vld_reg[ST_CRN-1] && (wrap_reg != '0), (32'(xrem_reg[DIV_ST-1]) < wrap_reg) && (32'(yrem_reg[DIV_ST-1]) < wrap_reg), "lattice remainder not below wrap period")
    `ASSERT_IMPLY(a_sample_range, clk, rst_n, vld_reg[ST_SMP], smp_ok, "corner sample out of range")

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import vnb2d_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int TAIL_CYCLES  = 40;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_we;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_wdata;
    logic                    in_valid;
    logic                    in_stall;
    logic [COORD_W-1:0]      coord_x;
    logic [COORD_W-1:0]      coord_y;
    logic                    out_valid;
    logic                    out_stall;
    logic signed [NOISE_W-1:0] noise_value;

    // shadow copy of the block's registers
    logic [FREQ_W-1:0] freq_q;
    logic [AMP_W-1:0]  amp_q;
    logic [WRAP_W-1:0] wrap_q;
    logic [SEED_W-1:0] seed_q;

    logic [NOISE_W-1:0] noise_due[$];
    logic [NOISE_W-1:0] noise_exp;
    int failures;
    int cycles;
    int gap_pct;
    int stall_pct;
    int stall_left;
    bit calm;

    value_noise_bilinear_2d u_top
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .noise_value (noise_value)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ---------------- noise predictor ----------------

    function automatic longint lattice_sample(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] h;
        logic [31:0] r;
        longint top;
        h = a ^ ~(b << 7);
        h = h - ((h << 23) ^ (b * HASH_MUL_B + HASH_ADD_B));
        h = h ^ (h << 24);
        h = h - ~(h << 6);
        r = h * HASH_MUL_R + HASH_ADD_R;
        top = longint'(r >> (31 - FRAC_BITS));
        return (longint'(1) << FRAC_BITS) - top;
    endfunction

    // >>> on a signed longint floors, as the blend needs
    function automatic longint mix_lerp(input longint a, input longint b, input longint t);
        return a + (((b - a) * t) >>> FRAC_BITS);
    endfunction

    function automatic logic [31:0] wrap_lattice(input logic [31:0] i);
        if (wrap_q != 0)
        begin
            return i % wrap_q;
        end
        return i;
    endfunction

    function automatic logic [NOISE_W-1:0] noise_at(input logic [31:0] x, input logic [31:0] y);
        logic [47:0] px;
        logic [47:0] py;
        logic [31:0] ix;
        logic [31:0] iy;
        logic [31:0] x0;
        logic [31:0] x1;
        logic [31:0] y0;
        logic [31:0] y1;
        longint tx;
        longint ty;
        longint top;
        longint bot;
        longint v;
        longint scaled;
        px = {16'd0, x} * {32'd0, freq_q};
        py = {16'd0, y} * {32'd0, freq_q};
        ix = 32'(px >> PROD_FRAC);
        iy = 32'(py >> PROD_FRAC);
        tx = longint'((px >> (PROD_FRAC - FRAC_BITS)) & ((48'd1 << FRAC_BITS) - 48'd1));
        ty = longint'((py >> (PROD_FRAC - FRAC_BITS)) & ((48'd1 << FRAC_BITS) - 48'd1));
        x0 = wrap_lattice(ix) ^ seed_q;
        x1 = wrap_lattice(ix + 32'd1) ^ seed_q;
        y0 = wrap_lattice(iy) ^ seed_q;
        y1 = wrap_lattice(iy + 32'd1) ^ seed_q;
        top = mix_lerp(lattice_sample(x0, y0), lattice_sample(x1, y0), tx);
        bot = mix_lerp(lattice_sample(x0, y1), lattice_sample(x1, y1), tx);
        v = mix_lerp(top, bot, ty);
        scaled = (v * longint'(amp_q)) >>> (FRAC_BITS - 8);
        return scaled[NOISE_W-1:0];
    endfunction

    // ---------------- drivers ----------------

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_FREQUENCY:   freq_q = data[FREQ_W-1:0];
            REG_AMPLITUDE:   amp_q  = data[AMP_W-1:0];
            REG_WRAP_PERIOD: wrap_q = data[WRAP_W-1:0];
            REG_SEED:        seed_q = data[SEED_W-1:0];
            default:         ;
        endcase
    endtask

    task automatic send_word(input logic [31:0] x, input logic [31:0] y);
        int gap;
        in_valid <= 1'b1;
        coord_x  <= x;
        coord_y  <= y;
        do
            @(posedge clk);
        while (in_stall);
        noise_due.push_back(noise_at(x, y));
        if (!calm && $urandom_range(0, 99) < gap_pct)
        begin
            gap = $urandom_range(1, 10);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // hold off until the pipe is empty; registers may be written after this
    task automatic quiesce();
        in_valid <= 1'b0;
        while (noise_due.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    function automatic logic [31:0] pick_coord();
        logic [31:0] c;
        case ($urandom_range(0, 5))
            0, 1:    c = $urandom;
            2:       c = $urandom_range(0, 32'h0004_0000);
            3:       c = ($urandom_range(0, 65535) << 16) | 32'hFFFF;
            4:       c = ($urandom_range(0, 65535) << 16) | $urandom_range(0, 1);
            default: c = $urandom_range(0, 1) ? 32'hFFFF_FFFF - $urandom_range(0, 255)
                                              : $urandom_range(0, 255);
        endcase
        return c;
    endfunction

    task automatic randomize_regs();
        logic [CFG_DATA_W-1:0] junk;
        junk = $urandom & 32'hFFFF_0000;
        case ($urandom_range(0, 4))
            0:       write_reg(REG_FREQUENCY, junk | 32'h0000);
            1:       write_reg(REG_FREQUENCY, junk | 32'hFFFF);
            2:       write_reg(REG_FREQUENCY, junk | 32'h0100);
            3:       write_reg(REG_FREQUENCY, junk | $urandom_range(1, 16'h0400));
            default: write_reg(REG_FREQUENCY, $urandom);
        endcase
        case ($urandom_range(0, 4))
            0:       write_reg(REG_AMPLITUDE, junk | 32'h0000);
            1:       write_reg(REG_AMPLITUDE, junk | 32'hFFFF);
            2:       write_reg(REG_AMPLITUDE, 32'h0100);
            default: write_reg(REG_AMPLITUDE, $urandom);
        endcase
        case ($urandom_range(0, 5))
            0, 1:    write_reg(REG_WRAP_PERIOD, 32'd0);
            2:       write_reg(REG_WRAP_PERIOD, $urandom_range(1, 16));
            3:       write_reg(REG_WRAP_PERIOD, $urandom_range(1, 32'h0100_0000));
            4:       write_reg(REG_WRAP_PERIOD, 32'hFFFF_FFFF);
            default: write_reg(REG_WRAP_PERIOD, $urandom);
        endcase
        case ($urandom_range(0, 2))
            0:       write_reg(REG_SEED, 32'd0);
            1:       write_reg(REG_SEED, 32'hFFFF_FFFF);
            default: write_reg(REG_SEED, $urandom);
        endcase
    endtask

    // ---------------- tests ----------------

    task automatic test_reset_config();
        send_word(32'h0000_0000, 32'h0000_0000);
        send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(32'h0000_8000, 32'h0000_8000);
        send_word(32'h0000_FFFF, 32'h0000_0000);
        send_word(32'h8000_0000, 32'h7FFF_FFFF);
        quiesce();
    endtask

    task automatic test_corner_cases();
        write_reg(REG_FREQUENCY, 32'hFFFF);
        write_reg(REG_AMPLITUDE, 32'hFFFF);
        send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(32'h1234_5678, 32'h0000_0000);
        send_word(32'h0000_0001, 32'h0000_0001);
        quiesce();
        // period 1 folds every corner onto lattice 0
        write_reg(REG_FREQUENCY, 32'h0100);
        write_reg(REG_AMPLITUDE, 32'h0100);
        write_reg(REG_WRAP_PERIOD, 32'd1);
        send_word(32'h0003_0000, 32'h0005_4000);
        quiesce();
        // far corner index 7 wraps back to 0
        write_reg(REG_WRAP_PERIOD, 32'd7);
        send_word(32'h0006_8000, 32'h0006_C000);
        send_word(32'h0000_8000, 32'h000D_FFFF);
        quiesce();
        write_reg(REG_WRAP_PERIOD, 32'hFFFF_FFFF);
        write_reg(REG_SEED, 32'hFFFF_FFFF);
        send_word(32'hFFFF_FFFF, 32'h0000_0000);
        send_word(32'h0001_0000, 32'hFFFF_0000);
        quiesce();
        // upper data bits beyond the register width are dropped
        write_reg(REG_FREQUENCY, 32'hFFFF_0080);
        write_reg(REG_AMPLITUDE, 32'hA5A5_0100);
        write_reg(REG_WRAP_PERIOD, 32'd0);
        write_reg(REG_SEED, 32'h5A5A_1234);
        send_word(32'h0042_9000, 32'h0017_3000);
        send_word(32'hDEAD_BEEF, 32'h0BAD_F00D);
        quiesce();
        write_reg(REG_FREQUENCY, 32'h0000);
        send_word(32'h9876_5432, 32'h1357_9BDF);
        quiesce();
        write_reg(REG_FREQUENCY, 32'h0333);
        write_reg(REG_AMPLITUDE, 32'h0000);
        send_word(32'h0123_4567, 32'h89AB_CDEF);
        send_word(32'hFFFF_FFFF, 32'h0000_FFFF);
        quiesce();
    endtask

    task automatic test_random_settings(input int phases, input int words);
        repeat (phases)
        begin
            randomize_regs();
            gap_pct   = $urandom_range(0, 2) * 25;
            stall_pct = $urandom_range(0, 2) * 25;
            repeat (words)
                send_word(pick_coord(), pick_coord());
            quiesce();
        end
    endtask

    task automatic test_back_to_back(input int words);
        calm = 1'b1;
        randomize_regs();
        repeat (words)
            send_word($urandom, $urandom);
    endtask

    // ---------------- result checking ----------------

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (noise_due.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("unexpected noise word %h at %0t", noise_value, $realtime);
            end
            else
            begin
                noise_exp = noise_due.pop_front();
                if (noise_value !== noise_exp)
                begin
                    failures++;
                    if (failures <= 10)
                        $display("noise_value mismatch: expected %h, got %h at %0t",
                                 noise_exp, noise_value, $realtime);
                end
            end
        end
    end

    // output-side backpressure in random bursts
    initial
    begin
        out_stall  <= 1'b0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (stall_left == 0)
            begin
                stall_left = $urandom_range(1, 10);
                out_stall <= !calm && ($urandom_range(0, 99) < stall_pct);
            end
            stall_left--;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        cycles    = 0;
        failures  = 0;
        calm      = 1'b0;
        gap_pct   = 25;
        stall_pct = 25;
        freq_q    = FREQ_RESET;
        amp_q     = AMP_RESET;
        wrap_q    = '0;
        seed_q    = '0;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_FREQUENCY;
        cfg_wdata <= '0;
        in_valid  <= 1'b0;
        coord_x   <= '0;
        coord_y   <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_config();
        test_corner_cases();
        test_random_settings(8, 160);
        test_back_to_back(150);

        quiesce();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (failures == 0 && noise_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
